[src/mpwd_pkg.sv]
// shared types and constants of the manchester pulse-width word decoder
package mpwd_pkg;

  // interval thresholds in percent of one bit period
  localparam logic [9:0] LenMin   = 10'd25;
  localparam logic [9:0] HalfMax  = 10'd75;
  localparam logic [9:0] FullMax  = 10'd125;
  localparam logic [9:0] ShortMax = 10'd175;
  localparam logic [9:0] LongMax  = 10'd225;

  localparam int DefWordBits = 16;
  localparam int OutWordBits = 16;

  // interval class
  typedef enum logic [2:0] {
    CLS_ERR   = 3'd0,
    CLS_HALF  = 3'd1,
    CLS_FULL  = 3'd2,
    CLS_SHORT = 3'd3,
    CLS_LONG  = 3'd4
  } pw_class_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_WAIT       = 3'd0,
    ST_HANDLE     = 3'd1,
    ST_CHECK      = 3'd2,
    ST_READY      = 3'd3,
    ST_ERR_LEN    = 3'd4,
    ST_ERR_STRUCT = 3'd5
  } status_e;

endpackage

[src/manchester_pulse_width_decoder_core.sv]
// top level of the manchester pulse-width word decoder
//
//   channel   direction  handshake                   payload
//   input     in         in_valid_i / in_stall_o     pulse_width_i
//   result    out        out_valid_o / out_stall_i   status_o, word_data_o, is_command_o
//   config    in         cfg_valid_i / cfg_ready_o   cfg_parity_seed_i
//
// one interval beat is taken every cycle while in_stall_o is low; its result beat reaches the outputs
// through the input register, then one pass of compare and shift logic into the result register
// decoder state is updated in the same pass that loads the result register
// a stalled result register holds the input register, which then stalls the input side
// reset clears all decoder state and the handshake flags; parity seed resets to 1
module manchester_pulse_width_decoder_core import mpwd_pkg::*; #(
  parameter int WORD_BITS = DefWordBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // interval input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [9:0]  pulse_width_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] word_data_o,
  output logic        is_command_o,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_parity_seed_i
);

  localparam int CntW = $clog2(WORD_BITS + 1);
  localparam int ExtW = (WORD_BITS > OutWordBits) ? WORD_BITS : OutWordBits;
  localparam logic [CntW-1:0] WordCnt = CntW'(WORD_BITS);

  // handshake and input register
  logic            s1_valid_q, s1_valid_d;
  logic [9:0]      s1_width_q;
  logic            advance;
  logic            in_accept;

  // decoder state
  logic                 parity_seed_q;
  logic                 line_q, line_d;
  logic [CntW-1:0]      bit_cnt_q, bit_cnt_d;
  logic [1:0]           half_units_q, half_units_d;
  logic [WORD_BITS-1:0] shift_q, shift_d;
  logic [WORD_BITS-1:0] held_q, held_d;
  logic                 cmd_pend_q, cmd_pend_d;
  logic                 cmd_held_q, cmd_held_d;
  logic                 parity_q, parity_d;
  logic                 in_frame_q, in_frame_d;

  // result register
  logic            out_valid_q;
  status_e         status_q, status_d;
  logic [15:0]     word_q;
  logic            cmd_q;

  pw_class_e       cls;
  logic            lvl;
  logic [2:0]      units;
  logic [ExtW-1:0] held_ext;

  // the result register frees when empty or when its beat is taken
  assign advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  mpwd_classify u_classify (
    .pulse_width_i (s1_width_q),
    .class_o       (cls)
  );

  // every interval marks an edge, so the level toggles first
  assign lvl = ~line_q;

  always_comb begin
    line_d       = lvl;
    bit_cnt_d    = bit_cnt_q;
    half_units_d = half_units_q;
    shift_d      = shift_q;
    held_d       = held_q;
    cmd_pend_d   = cmd_pend_q;
    cmd_held_d   = cmd_held_q;
    parity_d     = parity_q;
    in_frame_d   = in_frame_q;
    status_d     = ST_WAIT;
    units        = {1'b0, half_units_q};

    unique case (cls)
      CLS_HALF:  units = {1'b0, half_units_q} + 3'd1;
      CLS_FULL:  units = {1'b0, half_units_q} + 3'd2;
      CLS_SHORT,
      CLS_LONG: begin
        // sync opens a frame
        in_frame_d = 1'b1;
        shift_d    = '0;
        parity_d   = parity_seed_q;
        bit_cnt_d  = '0;
        units      = (cls == CLS_SHORT) ? 3'd1 : 3'd2;
        cmd_pend_d = ~lvl;
      end
      default: units = {1'b0, half_units_q};
    endcase

    if (cls == CLS_ERR) begin
      bit_cnt_d    = '0;
      half_units_d = '0;
      in_frame_d   = 1'b0;
      status_d     = ST_ERR_LEN;
    end else if (units >= 3'd3) begin
      // too many half-bit units in a row
      bit_cnt_d    = '0;
      half_units_d = '0;
      in_frame_d   = 1'b0;
      status_d     = ST_ERR_STRUCT;
    end else begin
      half_units_d = units[1:0];
      if (!in_frame_d) begin
        status_d = ST_WAIT;
      end else if (units == 3'd2 && bit_cnt_d < WordCnt) begin
        // one data bit complete
        shift_d      = {shift_d[WORD_BITS-2:0], lvl};
        parity_d     = parity_d ^ lvl;
        bit_cnt_d    = bit_cnt_d + CntW'(1);
        half_units_d = '0;
        status_d     = (bit_cnt_d < WordCnt) ? ST_HANDLE : ST_CHECK;
      end else if (units == 3'd2) begin
        // parity bit complete: hand the word over and close the frame
        held_d       = shift_d;
        shift_d      = '0;
        cmd_held_d   = cmd_pend_d;
        cmd_pend_d   = 1'b0;
        bit_cnt_d    = '0;
        half_units_d = '0;
        in_frame_d   = 1'b0;
        if (lvl != parity_d) begin
          // parity failed, so the line is inverted
          line_d     = ~lvl;
          held_d     = ~held_d;
          cmd_held_d = ~cmd_held_d;
        end
        status_d = ST_READY;
      end else begin
        status_d = (bit_cnt_d < WordCnt) ? ST_HANDLE : ST_CHECK;
      end
    end
  end

  assign held_ext = ExtW'(held_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      parity_seed_q <= 1'b1;
      line_q        <= 1'b0;
      bit_cnt_q     <= '0;
      half_units_q  <= '0;
      shift_q       <= '0;
      held_q        <= '0;
      cmd_pend_q    <= 1'b0;
      cmd_held_q    <= 1'b0;
      parity_q      <= 1'b0;
      in_frame_q    <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        parity_seed_q <= cfg_parity_seed_i;
      end
      if (advance) begin
        line_q       <= line_d;
        bit_cnt_q    <= bit_cnt_d;
        half_units_q <= half_units_d;
        shift_q      <= shift_d;
        held_q       <= held_d;
        cmd_pend_q   <= cmd_pend_d;
        cmd_held_q   <= cmd_held_d;
        parity_q     <= parity_d;
        in_frame_q   <= in_frame_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_width_q <= pulse_width_i;
    end
    if (advance) begin
      status_q <= status_d;
      word_q   <= held_ext[OutWordBits-1:0];
      cmd_q    <= cmd_held_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign word_data_o  = word_q;
  assign is_command_o = cmd_q;

  // a beat moving out of the input register always lands in the result register
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after advance");

  // the bit count is cleared whenever no frame is open
  a_idle_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> bit_cnt_q == '0)
    else $error("bit count set outside a frame");

  // the bit count never passes the word length
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= WordCnt)
    else $error("bit count beyond word length");

  // three half-bit units are never kept
  a_units_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_units_q != 2'd3)
    else $error("half-bit unit count overflow");

  // state only moves when a beat passes into the result register
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(line_q) && $stable(bit_cnt_q) && $stable(in_frame_q))
    else $error("decoder state changed without a beat");

endmodule

[src/mpwd_classify.sv]
// sorts one edge-to-edge interval into half bit, full bit, sync or length error
module mpwd_classify import mpwd_pkg::*; (
  input  logic [9:0] pulse_width_i,
  output pw_class_e  class_o
);

  always_comb begin
    priority if (pulse_width_i <= LenMin || pulse_width_i > LongMax) begin
      class_o = CLS_ERR;
    end else if (pulse_width_i <= HalfMax) begin
      class_o = CLS_HALF;
    end else if (pulse_width_i <= FullMax) begin
      class_o = CLS_FULL;
    end else if (pulse_width_i <= ShortMax) begin
      class_o = CLS_SHORT;
    end else begin
      class_o = CLS_LONG;
    end
  end

endmodule
